FILE: hw/rtl/clt_pkg.sv
// Shared constants, types and helpers for the idle connection timeout list.
package clt_pkg;

    localparam int MAX_CONN = 64;
    localparam int SLOT_W   = $clog2(MAX_CONN);
    localparam int COUNT_W  = $clog2(MAX_CONN + 1);
    localparam int ID_W     = 6;
    localparam int TIME_W   = 32;
    localparam int OP_W     = 2;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [ID_W-1:0]    conn_id_t;

    typedef enum logic [OP_W-1:0] {
        OP_TOUCH  = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SWEEP  = 2'd2
    } op_t;

    // Requests from the sequencer to the three list memories
    typedef struct packed {
        logic  la_we;
        slot_t la_waddr;
        time_t la_wdata;
        slot_t la_raddr;
        logic  ol_we;
        slot_t ol_waddr;
        slot_t ol_wdata;
        slot_t ol_raddr;
        logic  nl_we;
        slot_t nl_waddr;
        slot_t nl_wdata;
        slot_t nl_raddr;
    } mem_req_t;

    // Registered read data coming back from the memories
    typedef struct packed {
        time_t la_rdata;
        slot_t ol_rdata;
        slot_t nl_rdata;
    } mem_rsp_t;

    function automatic logic id_in_range(input conn_id_t id);
        return 32'(id) < MAX_CONN;
    endfunction

    function automatic slot_t to_slot(input conn_id_t id);
        return SLOT_W'(id);
    endfunction

endpackage

FILE: hw/rtl/clt_ram.sv
// Generic single write port, single registered read port memory.
module clt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/clt_age.sv
// Age unit: modulo time difference and compare against the idle timeout.
module clt_age
    import clt_pkg::*;
(
    input  time_t now_seconds,
    input  time_t last_active,
    input  time_t timeout,
    output logic  expired
);

    time_t age;

    // Wraps modulo 2^32 on purpose
    assign age     = now_seconds - last_active;
    assign expired = age > timeout;

endmodule

FILE: hw/rtl/clt_ctrl.sv
// Sequencer: list pointers, presence bits, timeout register and result output.
module clt_ctrl
    import clt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  operation,
    input  conn_id_t    conn_id,
    input  time_t       now_seconds,
    input  logic        cfg_we,
    input  time_t       cfg_data,
    output logic        busy,
    output logic        result_valid,
    output conn_id_t    conn_id_out,
    output logic        close_conn,
    output logic        last_result,
    output mem_req_t    mem_req,
    input  mem_rsp_t    mem_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UNLINK,
        S_PUSH,
        S_SWEEP,
        S_FLUSH
    } state_t;

    state_t              state_reg, state_next;
    logic [MAX_CONN-1:0] present_reg, present_next;
    slot_t               newest_reg, newest_next;
    slot_t               oldest_reg, oldest_next;
    count_t              count_reg, count_next;
    time_t               timeout_reg, timeout_next;
    time_t               now_reg, now_next;
    slot_t               id_reg, id_next;
    logic                touch_reg, touch_next;
    slot_t               pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                valid_reg, valid_next;
    conn_id_t            id_out_reg, id_out_next;
    logic                close_reg, close_next;
    logic                last_reg, last_next;

    logic     expired;
    logic     unlink_en;
    slot_t    ul_slot;
    slot_t    ul_o;
    slot_t    ul_n;
    logic     push_en;
    slot_t    push_slot;
    logic     emit_en;
    conn_id_t emit_id;
    logic     emit_close;
    logic     emit_last;
    slot_t    in_slot;

    clt_age u_age (
        .now_seconds (now_reg),
        .last_active (mem_rsp.la_rdata),
        .timeout     (timeout_reg),
        .expired     (expired)
    );

    assign in_slot = to_slot(conn_id);

    always_comb
    begin
        state_next      = state_reg;
        present_next    = present_reg;
        newest_next     = newest_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        timeout_next    = cfg_we ? cfg_data : timeout_reg;
        now_next        = now_reg;
        id_next         = id_reg;
        touch_next      = touch_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;

        mem_req          = '0;
        mem_req.la_raddr = oldest_reg;
        mem_req.ol_raddr = in_slot;
        mem_req.nl_raddr = in_slot;

        unlink_en  = 1'b0;
        ul_slot    = id_reg;
        ul_o       = mem_rsp.ol_rdata;
        ul_n       = mem_rsp.nl_rdata;
        push_en    = 1'b0;
        push_slot  = id_reg;
        emit_en    = 1'b0;
        emit_id    = '0;
        emit_close = 1'b0;
        emit_last  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    id_next    = in_slot;
                    touch_next = (operation == OP_TOUCH);
                    case (operation)
                        OP_TOUCH:
                        begin
                            if (id_in_range(conn_id))
                            begin
                                mem_req.la_we    = 1'b1;
                                mem_req.la_waddr = in_slot;
                                mem_req.la_wdata = now_seconds;
                                if (present_reg[in_slot])
                                begin
                                    state_next = S_UNLINK;
                                end
                                else
                                begin
                                    push_en   = 1'b1;
                                    push_slot = in_slot;
                                end
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (id_in_range(conn_id) && present_reg[in_slot])
                            begin
                                state_next = S_UNLINK;
                            end
                            else
                            begin
                                emit_en    = 1'b1;
                                emit_id    = conn_id;
                                emit_close = 1'b1;
                                emit_last  = 1'b1;
                            end
                        end
                        OP_SWEEP:
                        begin
                            now_next         = now_seconds;
                            pend_valid_next  = 1'b0;
                            mem_req.ol_raddr = oldest_reg;
                            mem_req.nl_raddr = oldest_reg;
                            if (count_reg == '0)
                            begin
                                emit_en   = 1'b1;
                                emit_last = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SWEEP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_UNLINK:
            begin
                unlink_en = 1'b1;
                if (touch_reg)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    emit_en    = 1'b1;
                    emit_id    = ID_W'(id_reg);
                    emit_close = 1'b1;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PUSH:
            begin
                push_en    = 1'b1;
                state_next = S_IDLE;
            end
            S_SWEEP:
            begin
                if (expired)
                begin
                    unlink_en = 1'b1;
                    ul_slot   = oldest_reg;
                    // Fetch the next oldest while this one leaves the list
                    mem_req.la_raddr = mem_rsp.nl_rdata;
                    mem_req.ol_raddr = mem_rsp.nl_rdata;
                    mem_req.nl_raddr = mem_rsp.nl_rdata;
                    if (pend_valid_reg)
                    begin
                        emit_en    = 1'b1;
                        emit_id    = ID_W'(pend_reg);
                        emit_close = 1'b1;
                    end
                    pend_next       = oldest_reg;
                    pend_valid_next = 1'b1;
                    if (count_reg == COUNT_W'(1))
                    begin
                        state_next = S_FLUSH;
                    end
                end
                else
                begin
                    emit_en   = 1'b1;
                    emit_last = 1'b1;
                    if (pend_valid_reg)
                    begin
                        emit_id    = ID_W'(pend_reg);
                        emit_close = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                emit_en    = 1'b1;
                emit_id    = ID_W'(pend_reg);
                emit_close = 1'b1;
                emit_last  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (unlink_en)
        begin
            if (ul_slot == newest_reg && ul_slot == oldest_reg)
            begin
                newest_next = '0;
                oldest_next = '0;
            end
            else if (ul_slot == newest_reg)
            begin
                newest_next = ul_o;
            end
            else if (ul_slot == oldest_reg)
            begin
                oldest_next = ul_n;
            end
            else
            begin
                mem_req.nl_we    = 1'b1;
                mem_req.nl_waddr = ul_o;
                mem_req.nl_wdata = ul_n;
                mem_req.ol_we    = 1'b1;
                mem_req.ol_waddr = ul_n;
                mem_req.ol_wdata = ul_o;
            end
            present_next[ul_slot] = 1'b0;
            if (count_reg != '0)
            begin
                count_next = count_reg - COUNT_W'(1);
            end
        end

        if (push_en)
        begin
            if (count_reg == '0)
            begin
                oldest_next = push_slot;
            end
            else
            begin
                mem_req.nl_we    = 1'b1;
                mem_req.nl_waddr = newest_reg;
                mem_req.nl_wdata = push_slot;
                mem_req.ol_we    = 1'b1;
                mem_req.ol_waddr = push_slot;
                mem_req.ol_wdata = newest_reg;
            end
            newest_next             = push_slot;
            present_next[push_slot] = 1'b1;
            count_next              = count_reg + COUNT_W'(1);
        end

        valid_next  = emit_en;
        id_out_next = emit_en ? emit_id : id_out_reg;
        close_next  = emit_en ? emit_close : close_reg;
        last_next   = emit_en ? emit_last : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            present_reg    <= '0;
            newest_reg     <= '0;
            oldest_reg     <= '0;
            count_reg      <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            now_reg        <= '0;
            id_reg         <= '0;
            touch_reg      <= 1'b0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            valid_reg      <= 1'b0;
            id_out_reg     <= '0;
            close_reg      <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            present_reg    <= present_next;
            newest_reg     <= newest_next;
            oldest_reg     <= oldest_next;
            count_reg      <= count_next;
            timeout_reg    <= timeout_next;
            now_reg        <= now_next;
            id_reg         <= id_next;
            touch_reg      <= touch_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            valid_reg      <= valid_next;
            id_out_reg     <= id_out_next;
            close_reg      <= close_next;
            last_reg       <= last_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign conn_id_out  = id_out_reg;
    assign close_conn   = close_reg;
    assign last_result  = last_reg;

    a_count_matches_present: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(present_reg))
        else $error("entry count disagrees with presence bits");

    a_empty_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> newest_reg == '0 && oldest_reg == '0)
        else $error("empty list with nonzero end pointers");

    a_ends_present: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> present_reg[newest_reg] && present_reg[oldest_reg])
        else $error("list end points at an absent slot");

    a_remove_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation == OP_REMOVE |=> busy || result_valid)
        else $error("remove neither unlinking nor answering");

    a_flush_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLUSH |-> pend_valid_reg)
        else $error("flush without a pending eviction");

endmodule

FILE: hw/rtl/idle_connection_timeout_list_core.sv
// Top level: least recently active connection list with idle timeout sweep.
// Touch of an absent slot: done at the accepting edge, busy stays low.
// Touch of a present slot: busy through the unlink state, then the relink at the newest end.
// Remove: result in the cycle after accept when absent; when present, after the unlink state.
// Sweep: one eviction per cycle through the shared age compare and the link memory
// read port; busy ends at the first unexpired entry, or after the flush state when it empties.
// Async active-low reset empties the list at once; no memory clearing pass.
module idle_connection_timeout_list_core
    import clt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  conn_id_t    conn_id,
    input  time_t       now_seconds,
    input  logic        idle_timeout_we,
    input  time_t       idle_timeout,
    output logic        result_valid,
    output conn_id_t    conn_id_out,
    output logic        close_conn,
    output logic        last_result
);

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;

    clt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .operation    (operation),
        .conn_id      (conn_id),
        .now_seconds  (now_seconds),
        .cfg_we       (idle_timeout_we),
        .cfg_data     (idle_timeout),
        .busy         (busy),
        .result_valid (result_valid),
        .conn_id_out  (conn_id_out),
        .close_conn   (close_conn),
        .last_result  (last_result),
        .mem_req      (mem_req),
        .mem_rsp      (mem_rsp)
    );

    clt_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_CONN)
    ) u_last_active (
        .clk   (clk),
        .we    (mem_req.la_we),
        .waddr (mem_req.la_waddr),
        .wdata (mem_req.la_wdata),
        .raddr (mem_req.la_raddr),
        .rdata (mem_rsp.la_rdata)
    );

    clt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_CONN)
    ) u_older_link (
        .clk   (clk),
        .we    (mem_req.ol_we),
        .waddr (mem_req.ol_waddr),
        .wdata (mem_req.ol_wdata),
        .raddr (mem_req.ol_raddr),
        .rdata (mem_rsp.ol_rdata)
    );

    clt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_CONN)
    ) u_newer_link (
        .clk   (clk),
        .we    (mem_req.nl_we),
        .waddr (mem_req.nl_waddr),
        .wdata (mem_req.nl_wdata),
        .raddr (mem_req.nl_raddr),
        .rdata (mem_rsp.nl_rdata)
    );

endmodule
